>>> hw/rtl/vector_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// vector_distance_unit_macros.svh
// assertion helpers used by the distance unit controller
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_UNIT_MACROS_SVH
`define VECTOR_DISTANCE_UNIT_MACROS_SVH

// property checked on every rising edge of aclk outside reset
`define VDU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen
`define VDU_NEVER(lbl, cond, msg) \
    `VDU_CHECK(lbl, !(cond), msg)

`endif

>>> hw/rtl/vdu_pkg.sv
// ----------------------------------------------------------------------------
// vdu_pkg
// widths, constants and controller/datapath interface types of the
// vector distance unit
// ----------------------------------------------------------------------------
package vdu_pkg;

    localparam int ELEM_W     = 16;
    localparam int SQ_W       = 42;
    localparam int NORM_W     = 41;
    localparam int DOT_W      = 42;
    localparam int DIST_W     = 42;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int HALF_W     = 5;
    localparam int SHIFT_W    = 7;
    localparam int DIV_N_W    = 119;
    localparam int QUO_W      = 18;
    localparam int CNT_W      = 7;
    localparam int ROOT_STEPS = 31;
    localparam int DIV_STEPS  = 119;
    localparam int FRAC_BITS  = 17;

    localparam logic [QUO_W-1:0] ONE_Q16 = QUO_W'(65536);

    typedef enum logic [1:0] {
        RES_L2,
        RES_ZERO,
        RES_COS
    } res_sel_t;

    typedef struct packed {
        logic     prod_load;
        logic     acc_add;
        logic     acc_clear;
        logic     norm_init;
        logic     norm_step;
        logic     root_init;
        logic     root_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic norm_zero;
        logic normed;
    } dp_sts_t;

endpackage

>>> hw/rtl/vdu_sqrt.sv
// ----------------------------------------------------------------------------
// vdu_sqrt
// bit-serial integer square root, one result bit per step, for a
// radicand already normalized into [2^60, 2^62)
// ----------------------------------------------------------------------------
module vdu_sqrt (
    input  logic                       aclk,
    input  logic                       init,
    input  logic                       step,
    input  logic [vdu_pkg::RAD_W-1:0]  rad,
    output logic [vdu_pkg::ROOT_W-1:0] root
);

    logic [vdu_pkg::RAD_W-1:0] x_reg, x_next;
    logic [vdu_pkg::RAD_W-1:0] r_reg, r_next;
    logic [vdu_pkg::RAD_W-1:0] b_reg, b_next;
    logic [vdu_pkg::RAD_W-1:0] trial;

    always_comb begin
        trial  = r_reg + b_reg;
        x_next = x_reg;
        r_next = r_reg;
        b_next = b_reg;
        if (init) begin
            x_next = rad;
            r_next = '0;
            b_next = vdu_pkg::RAD_W'(1) << (vdu_pkg::RAD_W - 2);
        end else if (step) begin
            if (x_reg >= trial) begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign root = r_reg[vdu_pkg::ROOT_W-1:0];

endmodule

>>> hw/rtl/vdu_datapath.sv
// ----------------------------------------------------------------------------
// vdu_datapath
// element products, saturating accumulators, norm normalization, two
// square root units, the denominator product and a restoring divider
// ----------------------------------------------------------------------------
module vdu_datapath #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  vdu_pkg::dp_cmd_t            cmd,
    output vdu_pkg::dp_sts_t            sts,
    input  logic [vdu_pkg::ELEM_W-1:0]  query_element,
    input  logic [vdu_pkg::ELEM_W-1:0]  base_element,
    input  logic                        last_element,
    output logic [vdu_pkg::DIST_W-1:0]  distance,
    output logic                        norm_zero
);

    localparam int SH = vdu_pkg::ELEM_W - ELEMENT_BITS;

    logic signed [vdu_pkg::ELEM_W-1:0] a_shl, b_shl, a_val, b_val;
    logic signed [vdu_pkg::ELEM_W:0]   d_val;
    logic signed [33:0]                d_mul;
    logic signed [31:0]                a_mul, b_mul, p_mul;

    logic [31:0]        dsq_reg;
    logic [30:0]        qsq_reg, bsq_reg;
    logic signed [31:0] dot_p_reg;
    logic               last_reg;

    logic [vdu_pkg::SQ_W-1:0]   sq_acc_reg;
    logic signed [vdu_pkg::DOT_W-1:0] dot_acc_reg;
    logic [vdu_pkg::NORM_W-1:0] qn_acc_reg, bn_acc_reg;

    logic [vdu_pkg::SQ_W:0]     sq_sum;
    logic signed [vdu_pkg::DOT_W:0] dot_sum;
    logic [vdu_pkg::NORM_W:0]   qn_sum, bn_sum;

    logic [vdu_pkg::RAD_W-1:0]  nq_reg, nb_reg;
    logic [vdu_pkg::HALF_W-1:0] hq_reg, hb_reg;
    logic [vdu_pkg::ROOT_W-1:0] root_q, root_b;

    logic [vdu_pkg::RAD_W-1:0]   den_reg;
    logic [vdu_pkg::DIV_N_W-1:0] n_reg;
    logic [vdu_pkg::RAD_W-1:0]   rem_reg;
    logic [vdu_pkg::QUO_W-1:0]   quo_reg;
    logic                        sat_reg;
    logic                        neg_reg;

    logic [vdu_pkg::DOT_W-1:0]   dot_mag;
    logic [vdu_pkg::SHIFT_W-1:0] shift_amt;
    logic [vdu_pkg::RAD_W:0]     trial;
    logic                        fits;

    logic [vdu_pkg::QUO_W:0]     quo_inc;
    logic [vdu_pkg::QUO_W-1:0]   mag, cos_dist;

    logic [vdu_pkg::DIST_W-1:0]  dist_reg;
    logic                        zero_reg;

    // element sign extension from ELEMENT_BITS
    always_comb begin
        a_shl = query_element <<< SH;
        b_shl = base_element <<< SH;
        a_val = a_shl >>> SH;
        b_val = b_shl >>> SH;
        d_val = {a_val[vdu_pkg::ELEM_W-1], a_val} - {b_val[vdu_pkg::ELEM_W-1], b_val};
        d_mul = d_val * d_val;
        a_mul = a_val * a_val;
        b_mul = b_val * b_val;
        p_mul = a_val * b_val;
    end

    always_ff @(posedge aclk) begin
        if (cmd.prod_load) begin
            dsq_reg   <= d_mul[31:0];
            qsq_reg   <= a_mul[30:0];
            bsq_reg   <= b_mul[30:0];
            dot_p_reg <= p_mul;
            last_reg  <= last_element;
        end
    end

    // saturating accumulation, unsigned overflow shows in the carry bit, dot overflow in the top two bits
    always_comb begin
        sq_sum  = {1'b0, sq_acc_reg} + (vdu_pkg::SQ_W+1)'(dsq_reg);
        qn_sum  = {1'b0, qn_acc_reg} + (vdu_pkg::NORM_W+1)'(qsq_reg);
        bn_sum  = {1'b0, bn_acc_reg} + (vdu_pkg::NORM_W+1)'(bsq_reg);
        dot_sum = {dot_acc_reg[vdu_pkg::DOT_W-1], dot_acc_reg}
                + (vdu_pkg::DOT_W+1)'(dot_p_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clear) begin
            sq_acc_reg  <= '0;
            dot_acc_reg <= '0;
            qn_acc_reg  <= '0;
            bn_acc_reg  <= '0;
        end else if (cmd.acc_add) begin
            sq_acc_reg <= sq_sum[vdu_pkg::SQ_W] ? '1 : sq_sum[vdu_pkg::SQ_W-1:0];
            qn_acc_reg <= qn_sum[vdu_pkg::NORM_W] ? '1 : qn_sum[vdu_pkg::NORM_W-1:0];
            bn_acc_reg <= bn_sum[vdu_pkg::NORM_W] ? '1 : bn_sum[vdu_pkg::NORM_W-1:0];
            if (dot_sum[vdu_pkg::DOT_W] != dot_sum[vdu_pkg::DOT_W-1]) begin
                dot_acc_reg <= dot_sum[vdu_pkg::DOT_W]
                             ? {1'b1, {(vdu_pkg::DOT_W-1){1'b0}}}
                             : {1'b0, {(vdu_pkg::DOT_W-1){1'b1}}};
            end else begin
                dot_acc_reg <= dot_sum[vdu_pkg::DOT_W-1:0];
            end
        end
    end

    // normalize each norm by even shifts until bit 60 or 61 is set
    always_ff @(posedge aclk) begin
        if (cmd.norm_init) begin
            nq_reg <= vdu_pkg::RAD_W'(qn_acc_reg);
            nb_reg <= vdu_pkg::RAD_W'(bn_acc_reg);
            hq_reg <= '0;
            hb_reg <= '0;
        end else if (cmd.norm_step) begin
            if (nq_reg[vdu_pkg::RAD_W-1 -: 2] == 2'b00) begin
                nq_reg <= nq_reg << 2;
                hq_reg <= hq_reg + 1'b1;
            end
            if (nb_reg[vdu_pkg::RAD_W-1 -: 2] == 2'b00) begin
                nb_reg <= nb_reg << 2;
                hb_reg <= hb_reg + 1'b1;
            end
        end
    end

    vdu_sqrt u_sqrt_q (
        .aclk (aclk),
        .init (cmd.root_init),
        .step (cmd.root_step),
        .rad  (nq_reg),
        .root (root_q)
    );

    vdu_sqrt u_sqrt_b (
        .aclk (aclk),
        .init (cmd.root_init),
        .step (cmd.root_step),
        .rad  (nb_reg),
        .root (root_b)
    );

    always_comb begin
        dot_mag   = dot_acc_reg[vdu_pkg::DOT_W-1] ? vdu_pkg::DOT_W'(-dot_acc_reg)
                                                  : vdu_pkg::DOT_W'(dot_acc_reg);
        shift_amt = vdu_pkg::SHIFT_W'(vdu_pkg::FRAC_BITS)
                  + vdu_pkg::SHIFT_W'(hq_reg) + vdu_pkg::SHIFT_W'(hb_reg);
        trial     = {rem_reg, n_reg[vdu_pkg::DIV_N_W-1]};
        fits      = trial >= {1'b0, den_reg};
    end

    // restoring division of |dot| << shift by the root product
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            den_reg <= root_q * root_b;
            n_reg   <= vdu_pkg::DIV_N_W'(dot_mag) << shift_amt;
            neg_reg <= dot_acc_reg[vdu_pkg::DOT_W-1];
            rem_reg <= '0;
            quo_reg <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.div_step) begin
            n_reg   <= n_reg << 1;
            rem_reg <= fits ? vdu_pkg::RAD_W'(trial - {1'b0, den_reg})
                            : trial[vdu_pkg::RAD_W-1:0];
            quo_reg <= {quo_reg[vdu_pkg::QUO_W-2:0], fits};
            sat_reg <= sat_reg | quo_reg[vdu_pkg::QUO_W-1];
        end
    end

    // round half up, clamp to one, apply sign of the dot product
    always_comb begin
        quo_inc  = {1'b0, quo_reg} + 1'b1;
        mag      = quo_inc[vdu_pkg::QUO_W:1];
        if (sat_reg || mag > vdu_pkg::ONE_Q16) begin
            mag = vdu_pkg::ONE_Q16;
        end
        cos_dist = neg_reg ? vdu_pkg::ONE_Q16 + mag : vdu_pkg::ONE_Q16 - mag;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.res_sel)
                vdu_pkg::RES_L2: begin
                    dist_reg <= sq_acc_reg;
                    zero_reg <= 1'b0;
                end
                vdu_pkg::RES_ZERO: begin
                    dist_reg <= vdu_pkg::DIST_W'(vdu_pkg::ONE_Q16);
                    zero_reg <= 1'b1;
                end
                default: begin
                    dist_reg <= vdu_pkg::DIST_W'(cos_dist);
                    zero_reg <= 1'b0;
                end
            endcase
        end
    end

    assign distance      = dist_reg;
    assign norm_zero     = zero_reg;
    assign sts.last      = last_reg;
    assign sts.norm_zero = (qn_acc_reg == '0) || (bn_acc_reg == '0);
    assign sts.normed    = (nq_reg[vdu_pkg::RAD_W-1 -: 2] != 2'b00)
                        && (nb_reg[vdu_pkg::RAD_W-1 -: 2] != 2'b00);

endmodule

>>> hw/rtl/vdu_ctrl.sv
// ----------------------------------------------------------------------------
// vdu_ctrl
// sequencer of the distance unit: element handshake, mode register,
// step counts of the root and divide phases, output valid
// ----------------------------------------------------------------------------
`include "vector_distance_unit_macros.svh"

module vdu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic             cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output vdu_pkg::dp_cmd_t cmd,
    input  vdu_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DECIDE,
        ST_NORM,
        ST_ROOT,
        ST_DIVIDE,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic                     mode_reg, mode_next;
    logic                     valid_reg, valid_next;
    logic [vdu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    vdu_pkg::res_sel_t        sel_reg, sel_next;
    logic                     out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        mode_next  = cfg_wen ? cfg_wdata : mode_reg;
        valid_next = (valid_reg && m_tready) ? 1'b0 : valid_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.res_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.prod_load = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = sts.last ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE: begin
                if (!mode_reg) begin
                    sel_next   = vdu_pkg::RES_L2;
                    state_next = ST_FINISH;
                end else if (sts.norm_zero) begin
                    sel_next   = vdu_pkg::RES_ZERO;
                    state_next = ST_FINISH;
                end else begin
                    cmd.norm_init = 1'b1;
                    state_next    = ST_NORM;
                end
            end
            ST_NORM: begin
                if (sts.normed) begin
                    cmd.root_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_ROOT;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == vdu_pkg::CNT_W'(vdu_pkg::ROOT_STEPS - 1)) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == vdu_pkg::CNT_W'(vdu_pkg::DIV_STEPS - 1)) begin
                    sel_next   = vdu_pkg::RES_COS;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            sel_reg   <= vdu_pkg::RES_L2;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    `VDU_NEVER(a_no_overwrite, cmd.out_load && valid_reg && !m_tready, "result overwritten")
    `VDU_CHECK(a_acc_follows, s_tvalid && s_tready |=> state_reg == ST_ACC, "no accumulate")
    `VDU_NEVER(a_div_bound, state_reg == ST_DIVIDE && cnt_reg >= vdu_pkg::CNT_W'(vdu_pkg::DIV_STEPS), "divide overrun")
    `VDU_CHECK(a_cos_path, state_reg == ST_MULT |=> state_reg == ST_DIVIDE && cnt_reg == '0, "bad divide start")

endmodule

>>> hw/rtl/vector_distance_unit.sv
// ----------------------------------------------------------------------------
// vector_distance_unit
// squared euclidean or cosine distance over a stream of element pairs
// ----------------------------------------------------------------------------
//  channel   dir   transfer contents
//  s_axis    in    tdata: query_element, base_element; tlast: last_element
//  m_axis    out   tdata: distance; tuser: norm_zero
//  cfg       in    cfg_wdata: mode select (1 = cosine), written when cfg_wen is high
//
//  each element pair passes the product registers, then the accumulators, and
//  the next pair is taken only after that; a vector end adds decide and finish,
//  in cosine mode on nonzero norms also normalize, 31 root and 119 divide steps
//  elements of the next vector are taken while a result waits in m_tdata;
//  a new result stalls until the previous one is transferred
//  aresetn is synchronous, active low, and clears mode and accumulators
// ----------------------------------------------------------------------------
module vector_distance_unit #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] query_element, [31:16] base_element
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [41:0] distance, [47:42] zero
    output logic        m_tuser    // [0] norm_zero
);

    vdu_pkg::dp_cmd_t              cmd;
    vdu_pkg::dp_sts_t              sts;
    logic [vdu_pkg::DIST_W-1:0]    distance;

    vdu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vdu_datapath #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .query_element (s_tdata[15:0]),
        .base_element  (s_tdata[31:16]),
        .last_element  (s_tlast),
        .distance      (distance),
        .norm_zero     (m_tuser)
    );

    assign m_tdata = {6'b0, distance};

endmodule
